@@ hdl/lpm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lpm_pkg
// Shared types, constants and mask helpers for the IPv4 longest prefix match
// unit.
// ----------------------------------------------------------------------------
package lpm_pkg;

  // address and field widths
  localparam int ADDR_BITS     = 32;
  localparam int TOP_BIT       = 31;
  localparam int LEN_BITS      = 6;
  localparam int IDX_BITS      = 4;
  localparam int PORT_W        = 4;

  // parameter defaults and limits
  localparam int ENTRIES_DEF   = 16;
  localparam int PORT_BITS_DEF = 4;
  localparam int MAX_SLOTS     = 16;   // slots reachable by a 4-bit index

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH   = 2;

  // command codes
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  // one word as it travels from front to back
  typedef struct packed {
    logic                 cmd;
    logic [IDX_BITS-1:0]  index;
    logic                 valid;
    logic [ADDR_BITS-1:0] key;    // destination on a write, address on a lookup
    logic [ADDR_BITS-1:0] keep;   // leading-ones part of the mask
    logic [LEN_BITS-1:0]  len;    // prefix length
    logic [PORT_W-1:0]    port;
  } item_t;

  // keep only the leading ones of a mask: bit i survives when bits 31..i are set
  function automatic logic [ADDR_BITS-1:0] keep_mask(input logic [ADDR_BITS-1:0] mask);
    logic [ADDR_BITS-1:0] k;
    k = mask;
    for (int s = 1; s < ADDR_BITS; s = s * 2) begin
      k = k & ((k >> s) | ~({ADDR_BITS{1'b1}} >> s));
    end
    return k;
  endfunction

  // population count of a 32-bit word as an adder tree
  function automatic logic [LEN_BITS-1:0] ones_count(input logic [ADDR_BITS-1:0] w);
    logic [1:0] s1 [16];
    logic [2:0] s2 [8];
    logic [3:0] s3 [4];
    logic [4:0] s4 [2];
    for (int i = 0; i < 16; i++) begin
      s1[i] = {1'b0, w[2*i]} + {1'b0, w[2*i+1]};
    end
    for (int i = 0; i < 8; i++) begin
      s2[i] = {1'b0, s1[2*i]} + {1'b0, s1[2*i+1]};
    end
    for (int i = 0; i < 4; i++) begin
      s3[i] = {1'b0, s2[2*i]} + {1'b0, s2[2*i+1]};
    end
    for (int i = 0; i < 2; i++) begin
      s4[i] = {1'b0, s3[2*i]} + {1'b0, s3[2*i+1]};
    end
    return {1'b0, s4[0]} + {1'b0, s4[1]};
  endfunction

endpackage
`default_nettype wire

@@ hdl/lpm_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lpm_front
// Accepts input words, folds the mask to its leading ones and derives the
// prefix length, then hands the word to the queue.
// ----------------------------------------------------------------------------
module lpm_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          cmd_i,
  input  wire logic [lpm_pkg::IDX_BITS-1:0]  entry_index_i,
  input  wire logic                          entry_valid_i,
  input  wire logic [lpm_pkg::ADDR_BITS-1:0] entry_dest_i,
  input  wire logic [lpm_pkg::ADDR_BITS-1:0] entry_mask_i,
  input  wire logic [lpm_pkg::PORT_W-1:0]    entry_port_i,
  input  wire logic [lpm_pkg::ADDR_BITS-1:0] lookup_addr_i,
  output logic                               push_valid_o,
  input  wire logic                          push_ready_i,
  output lpm_pkg::item_t                     push_item_o
);
  import lpm_pkg::*;

  logic  stage_valid_q;
  item_t stage_q;
  item_t stage_d;
  logic  accept;

  // stage is free when empty or draining into the queue this cycle
  assign in_ready_o = !stage_valid_q || push_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // classify the incoming word
  always_comb begin
    stage_d       = '0;
    stage_d.cmd   = cmd_i;
    stage_d.index = entry_index_i;
    stage_d.valid = entry_valid_i;
    stage_d.key   = (cmd_i == CMD_LOOKUP) ? lookup_addr_i : entry_dest_i;
    stage_d.keep  = keep_mask(entry_mask_i);
    stage_d.port  = entry_port_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else if (accept) begin
      stage_valid_q <= 1'b1;
    end else if (push_ready_i) begin
      stage_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stage_q <= stage_d;
    end
  end

  // prefix length is the count of kept mask bits
  always_comb begin
    push_item_o     = stage_q;
    push_item_o.len = ones_count(stage_q.keep);
  end

  assign push_valid_o = stage_valid_q;

endmodule
`default_nettype wire

@@ hdl/lpm_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lpm_queue
// Short first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
module lpm_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_valid_i,
  output logic                push_ready_o,
  input  wire lpm_pkg::item_t push_item_i,
  output logic                pop_valid_o,
  input  wire logic           pop_ready_i,
  output lpm_pkg::item_t      pop_item_o
);
  import lpm_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  item_t         buf_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_q;
  logic [PW-1:0] rd_ptr_q;
  logic [CW-1:0] cnt_q;
  logic          push;
  logic          pop;

  assign push_ready_o = (cnt_q != CW'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = buf_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule
`default_nettype wire

@@ hdl/lpm_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lpm_back
// Holds the route table, applies writes and walks the table one slot per
// cycle for a lookup, keeping the longest match found so far.
// ----------------------------------------------------------------------------
module lpm_back #(
  parameter int ENTRIES   = lpm_pkg::ENTRIES_DEF,
  parameter int PORT_BITS = lpm_pkg::PORT_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         pop_valid_i,
  output logic                              pop_ready_o,
  input  wire lpm_pkg::item_t               pop_item_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic                              hit_o,
  output logic [lpm_pkg::PORT_W-1:0]        out_port_o,
  output logic [lpm_pkg::LEN_BITS-1:0]      match_len_o
);
  import lpm_pkg::*;

  // only the first min(ENTRIES,16) slots exist and can ever be written
  localparam int SLOTS = (ENTRIES < MAX_SLOTS) ? ENTRIES : MAX_SLOTS;
  localparam int IW    = $clog2(SLOTS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  state_e                 state_q;
  logic [IW-1:0]          idx_q;
  logic [ADDR_BITS-1:0]   addr_q;
  logic                   hit_q;
  logic [LEN_BITS-1:0]    best_len_q;
  logic [PORT_BITS-1:0]   best_port_q;
  logic [SLOTS-1:0]       vld_q;
  logic                   cmp_en_q;
  logic                   rd_vld_q;
  logic                   out_valid_q;
  logic                   out_hit_q;
  logic [PORT_W-1:0]      out_port_q;
  logic [LEN_BITS-1:0]    out_len_q;

  // table memory
  logic [ADDR_BITS-1:0]   mem_dest [SLOTS];
  logic [ADDR_BITS-1:0]   mem_keep [SLOTS];
  logic [LEN_BITS-1:0]    mem_len  [SLOTS];
  logic [PORT_BITS-1:0]   mem_port [SLOTS];
  logic [ADDR_BITS-1:0]   rd_dest_q;
  logic [ADDR_BITS-1:0]   rd_keep_q;
  logic [LEN_BITS-1:0]    rd_len_q;
  logic [PORT_BITS-1:0]   rd_port_q;

  logic                   pop;
  logic                   in_range;
  logic                   wr_en;
  logic [IW-1:0]          wr_addr;
  logic                   rd_en;
  logic                   match;
  logic                   better;
  logic                   out_free;

  assign pop_ready_o = (state_q == ST_IDLE);
  assign pop         = pop_valid_i && pop_ready_o;
  assign in_range    = {1'b0, pop_item_i.index} < (IDX_BITS + 1)'(SLOTS);
  assign wr_en       = pop && (pop_item_i.cmd == CMD_WRITE) && in_range;
  assign wr_addr     = pop_item_i.index[IW-1:0];
  assign rd_en       = (state_q == ST_SCAN);
  assign out_free    = !out_valid_q || out_ready_i;

  // compare the slot read last cycle against the address
  assign match  = rd_vld_q && (((addr_q ^ rd_dest_q) & rd_keep_q) == '0);
  assign better = cmp_en_q && match && (!hit_q || (rd_len_q > best_len_q));

  // single-port table: write on a write word, read during the scan
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_dest[wr_addr] <= pop_item_i.key;
      mem_keep[wr_addr] <= pop_item_i.keep;
      mem_len[wr_addr]  <= pop_item_i.len;
      mem_port[wr_addr] <= PORT_BITS'(pop_item_i.port);
    end
    if (rd_en) begin
      rd_dest_q <= mem_dest[idx_q];
      rd_keep_q <= mem_keep[idx_q];
      rd_len_q  <= mem_len[idx_q];
      rd_port_q <= mem_port[idx_q];
    end
  end

  // sequencer, valid bits, best match and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      addr_q      <= '0;
      hit_q       <= 1'b0;
      best_len_q  <= '0;
      best_port_q <= '0;
      vld_q       <= '0;
      cmp_en_q    <= 1'b0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
      out_hit_q   <= 1'b0;
      out_port_q  <= '0;
      out_len_q   <= '0;
    end else begin
      cmp_en_q <= rd_en;
      if (rd_en) begin
        rd_vld_q <= vld_q[idx_q];
      end

      if (wr_en) begin
        vld_q[wr_addr] <= pop_item_i.valid;
      end

      if (better) begin
        hit_q       <= 1'b1;
        best_len_q  <= rd_len_q;
        best_port_q <= rd_port_q;
      end

      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (pop && (pop_item_i.cmd == CMD_LOOKUP)) begin
            addr_q      <= pop_item_i.key;
            idx_q       <= '0;
            hit_q       <= 1'b0;
            best_len_q  <= '0;
            best_port_q <= '0;
            state_q     <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (idx_q == IW'(SLOTS - 1)) begin
            state_q <= ST_DRAIN;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        ST_DRAIN: begin
          // last slot is compared this cycle
          state_q <= ST_FINISH;
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_hit_q   <= hit_q;
            out_port_q  <= PORT_W'(best_port_q);
            out_len_q   <= best_len_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = out_hit_q;
  assign out_port_o  = out_port_q;
  assign match_len_o = out_len_q;

endmodule
`default_nettype wire

@@ hdl/ipv4_longest_prefix_match_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4_longest_prefix_match_unit
// Routing table with longest prefix match lookup.
// ----------------------------------------------------------------------------
// A write word (cmd 0) stores one route slot and returns nothing; a lookup
// word (cmd 1) returns one result: hit, the port of the longest matching
// valid route (ties to the lowest slot) and its prefix length, with port and
// length 0 on a miss. A mask counts only its leading ones, so a mask with a
// clear top bit is a default route that matches every address. Words pass a
// registered front stage and a two-word queue; the back applies a write as it
// takes the word, and for a lookup it reads the single-port route memory one
// slot per cycle. Slots at and above 16, and writes to a slot index not below
// ENTRIES, are never used. Valid bits clear at reset; no clearing pass is
// needed.
// ----------------------------------------------------------------------------
module ipv4_longest_prefix_match_unit #(
  parameter int ENTRIES   = lpm_pkg::ENTRIES_DEF,
  parameter int PORT_BITS = lpm_pkg::PORT_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          cmd_i,
  input  wire logic [lpm_pkg::IDX_BITS-1:0]  entry_index_i,
  input  wire logic                          entry_valid_i,
  input  wire logic [lpm_pkg::ADDR_BITS-1:0] entry_dest_i,
  input  wire logic [lpm_pkg::ADDR_BITS-1:0] entry_mask_i,
  input  wire logic [lpm_pkg::PORT_W-1:0]    entry_port_i,
  input  wire logic [lpm_pkg::ADDR_BITS-1:0] lookup_addr_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               hit_o,
  output logic [lpm_pkg::PORT_W-1:0]         out_port_o,
  output logic [lpm_pkg::LEN_BITS-1:0]       match_len_o
);
  import lpm_pkg::*;

  logic  push_valid;
  logic  push_ready;
  item_t push_item;
  logic  pop_valid;
  logic  pop_ready;
  item_t pop_item;

  // classify incoming words
  lpm_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cmd_i         (cmd_i),
    .entry_index_i (entry_index_i),
    .entry_valid_i (entry_valid_i),
    .entry_dest_i  (entry_dest_i),
    .entry_mask_i  (entry_mask_i),
    .entry_port_i  (entry_port_i),
    .lookup_addr_i (lookup_addr_i),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_item_o   (push_item)
  );

  // decouple front from back
  lpm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  // table and lookup engine
  lpm_back #(
    .ENTRIES   (ENTRIES),
    .PORT_BITS (PORT_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_item_i  (pop_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .hit_o       (hit_o),
    .out_port_o  (out_port_o),
    .match_len_o (match_len_o)
  );

endmodule
`default_nettype wire
